>>> rtl/core/btc_pkg.sv
// shared types and constants for the binary threshold centroid block
`default_nettype none

package btc_pkg;

  localparam int PIXEL_W    = 8;
  localparam int LW_W       = 10;
  localparam int AREA_W     = 19;
  localparam int SUM_W      = 27;
  localparam int CENT_W     = 9;
  localparam int ITER_W     = 5;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [PIXEL_W-1:0] THRESHOLD_RESET  = 8'd139;
  localparam logic [LW_W-1:0]    LINE_WIDTH_RESET = 10'd512;

  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

  // first step of the bit-serial divide, counting down to zero
  localparam logic [ITER_W-1:0] DIV_LAST = ITER_W'(SUM_W - 1);

  // register index, taken from paddr[2]
  localparam logic REG_THRESHOLD  = 1'b0;
  localparam logic REG_LINE_WIDTH = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV_ROW,
    S_DIV_COL
  } btc_state_t;

endpackage

`default_nettype wire

>>> rtl/core/binary_threshold_centroid.sv
// binary threshold centroid: foreground mask, area and centroid per frame
//
// Pixels arrive on the input channel (pixel, end_of_frame) with in_valid and
// in_stall, in row-major order; the block tracks row and column itself, the
// column wrapping at line_width. One request in gives one request out on the
// output channel (out_valid, out_stall), carrying the foreground bit and, on
// the end-of-frame pixel, area, centroids and the empty-frame flag.
// An ordinary pixel comes out in the cycle after it is taken, and a new
// pixel is taken in the same cycle, so while out_stall is low the stream
// runs at one pixel per cycle. An end-of-frame pixel with foreground area
// runs a shared restoring divider, one quotient bit per cycle, for the row
// sum, then for the column sum, while in_stall is high; the result follows
// the column divide. An empty frame reports in the cycle after it is taken.
// While out_stall holds a waiting result, in_stall is high and the result
// stays unchanged. Reset (rst, synchronous) empties the output register,
// clears counters and sums and loads threshold 139 and line width 512.
// Registers sit on an APB-style port: threshold at 0x0, line_width at 0x4.
`default_nettype none

module binary_threshold_centroid
  import btc_pkg::*;
#(
  parameter int MAX_ROWS    = 512,
  parameter int MAX_COLUMNS = 512
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  // pixel input
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [PIXEL_W-1:0]    pixel,
  input  wire logic                  end_of_frame,
  // result output
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       foreground,
  output logic                       frame_done,
  output logic      [AREA_W-1:0]     area,
  output logic      [CENT_W-1:0]     centroid_row,
  output logic      [CENT_W-1:0]     centroid_col,
  output logic                       empty_frame
);

  localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam logic [SUM_W-1:0] ROW_LIMIT = SUM_W'(MAX_ROWS - 1);
  localparam logic [SUM_W-1:0] COL_LIMIT = SUM_W'(MAX_COLUMNS - 1);

  // configuration registers
  logic [PIXEL_W-1:0] threshold;
  logic [LW_W-1:0]    line_width;

  // frame state
  logic [COL_W-1:0]  column_count, column_count_next;
  logic [ROW_W-1:0]  row_count, row_count_next;
  logic [AREA_W-1:0] area_sum, area_sum_next;
  logic [SUM_W-1:0]  row_index_sum, row_index_sum_next;
  logic [SUM_W-1:0]  col_index_sum, col_index_sum_next;

  // sequencer and divider
  btc_state_t        state, state_next;
  logic [ITER_W-1:0] iter, iter_next;
  logic [AREA_W-1:0] rem, rem_next;
  logic [SUM_W-1:0]  dq, dq_next;
  logic              fg_hold, fg_hold_next;

  // output register next values
  logic              out_valid_next;
  logic              foreground_next;
  logic              frame_done_next;
  logic [AREA_W-1:0] area_next;
  logic [CENT_W-1:0] centroid_row_next;
  logic [CENT_W-1:0] centroid_col_next;
  logic              empty_frame_next;

  logic              in_accept;
  logic              cfg_write;
  logic              fg;
  logic [LW_W-1:0]   width_eff;
  logic [COL_W:0]    col_inc;
  logic              col_wrap;
  logic              row_room;
  logic [AREA_W:0]   area_add;
  logic [AREA_W-1:0] area_acc;
  logic [SUM_W:0]    row_add;
  logic [SUM_W-1:0]  row_acc;
  logic [SUM_W:0]    col_add;
  logic [SUM_W-1:0]  col_acc;
  logic [AREA_W-1:0] area_fin;
  logic [SUM_W-1:0]  row_fin;
  logic [SUM_W-1:0]  col_fin;
  logic [AREA_W:0]   shifted;
  logic [AREA_W-1:0] diff;
  logic              q_bit;
  logic [AREA_W-1:0] rem_step;
  logic [SUM_W-1:0]  q_step;
  logic [SUM_W-1:0]  q_limit;
  logic [SUM_W-1:0]  q_clamp;

  // ---------------- configuration port ----------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      REG_THRESHOLD:  prdata = CFG_DATA_W'(threshold);
      REG_LINE_WIDTH: prdata = CFG_DATA_W'(line_width);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= THRESHOLD_RESET;
      line_width <= LINE_WIDTH_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_THRESHOLD:  threshold  <= pwdata[PIXEL_W-1:0];
        REG_LINE_WIDTH: line_width <= pwdata[LW_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- per-pixel arithmetic ----------------
  assign in_stall  = (state != S_IDLE) || (out_valid && out_stall);
  assign in_accept = in_valid && !in_stall;
  assign fg        = pixel < threshold;

  // line width clamped into 1..MAX_COLUMNS
  always_comb begin
    if (line_width == '0) begin
      width_eff = LW_W'(1);
    end else if (32'(line_width) > 32'(MAX_COLUMNS)) begin
      width_eff = LW_W'(MAX_COLUMNS);
    end else begin
      width_eff = line_width;
    end
  end

  assign col_inc  = {1'b0, column_count} + (COL_W + 1)'(1);
  assign col_wrap = 32'(col_inc) >= 32'(width_eff);
  assign row_room = 32'(row_count) < (MAX_ROWS - 1);

  // saturating accumulators
  assign area_add = {1'b0, area_sum} + (AREA_W + 1)'(1);
  assign area_acc = (area_add >= {1'b0, AREA_MAX}) ? AREA_MAX : area_add[AREA_W-1:0];
  assign row_add  = {1'b0, row_index_sum} + (SUM_W + 1)'(row_count);
  assign row_acc  = (row_add >= {1'b0, SUM_MAX}) ? SUM_MAX : row_add[SUM_W-1:0];
  assign col_add  = {1'b0, col_index_sum} + (SUM_W + 1)'(column_count);
  assign col_acc  = (col_add >= {1'b0, SUM_MAX}) ? SUM_MAX : col_add[SUM_W-1:0];

  assign area_fin = fg ? area_acc : area_sum;
  assign row_fin  = fg ? row_acc : row_index_sum;
  assign col_fin  = fg ? col_acc : col_index_sum;

  // ---------------- shared divider step ----------------
  // restoring division, one quotient bit per cycle, divisor is the area
  assign shifted  = {rem, dq[SUM_W-1]};
  assign diff     = shifted[AREA_W-1:0] - area_sum;
  assign q_bit    = shifted >= {1'b0, area_sum};
  assign rem_step = q_bit ? diff : shifted[AREA_W-1:0];
  assign q_step   = {dq[SUM_W-2:0], q_bit};
  assign q_limit  = (state == S_DIV_ROW) ? ROW_LIMIT : COL_LIMIT;
  assign q_clamp  = (q_step > q_limit) ? q_limit : q_step;

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      column_count  <= '0;
      row_count     <= '0;
      area_sum      <= '0;
      row_index_sum <= '0;
      col_index_sum <= '0;
    end else begin
      state         <= state_next;
      out_valid     <= out_valid_next;
      column_count  <= column_count_next;
      row_count     <= row_count_next;
      area_sum      <= area_sum_next;
      row_index_sum <= row_index_sum_next;
      col_index_sum <= col_index_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    iter         <= iter_next;
    rem          <= rem_next;
    dq           <= dq_next;
    fg_hold      <= fg_hold_next;
    foreground   <= foreground_next;
    frame_done   <= frame_done_next;
    area         <= area_next;
    centroid_row <= centroid_row_next;
    centroid_col <= centroid_col_next;
    empty_frame  <= empty_frame_next;
  end

  always_comb begin
    state_next         = state;
    column_count_next  = column_count;
    row_count_next     = row_count;
    area_sum_next      = area_sum;
    row_index_sum_next = row_index_sum;
    col_index_sum_next = col_index_sum;
    iter_next          = iter;
    rem_next           = rem;
    dq_next            = dq;
    fg_hold_next       = fg_hold;
    out_valid_next     = out_valid && out_stall;
    foreground_next    = foreground;
    frame_done_next    = frame_done;
    area_next          = area;
    centroid_row_next  = centroid_row;
    centroid_col_next  = centroid_col;
    empty_frame_next   = empty_frame;

    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          foreground_next = fg;
          fg_hold_next    = fg;
          if (end_of_frame) begin
            column_count_next = '0;
            row_count_next    = '0;
            if (area_fin == '0) begin
              out_valid_next     = 1'b1;
              frame_done_next    = 1'b1;
              empty_frame_next   = 1'b1;
              area_next          = '0;
              centroid_row_next  = '0;
              centroid_col_next  = '0;
              area_sum_next      = '0;
              row_index_sum_next = '0;
              col_index_sum_next = '0;
            end else begin
              area_sum_next      = area_fin;
              row_index_sum_next = row_fin;
              col_index_sum_next = col_fin;
              dq_next            = row_fin;
              rem_next           = '0;
              iter_next          = DIV_LAST;
              state_next         = S_DIV_ROW;
            end
          end else begin
            area_sum_next      = area_fin;
            row_index_sum_next = row_fin;
            col_index_sum_next = col_fin;
            if (col_wrap) begin
              column_count_next = '0;
              if (row_room) begin
                row_count_next = row_count + ROW_W'(1);
              end
            end else begin
              column_count_next = col_inc[COL_W-1:0];
            end
            out_valid_next    = 1'b1;
            frame_done_next   = 1'b0;
            empty_frame_next  = 1'b0;
            area_next         = '0;
            centroid_row_next = '0;
            centroid_col_next = '0;
          end
        end
      end

      S_DIV_ROW: begin
        rem_next  = rem_step;
        dq_next   = q_step;
        iter_next = iter - ITER_W'(1);
        if (iter == '0) begin
          centroid_row_next = q_clamp[CENT_W-1:0];
          dq_next           = col_index_sum;
          rem_next          = '0;
          iter_next         = DIV_LAST;
          state_next        = S_DIV_COL;
        end
      end

      S_DIV_COL: begin
        rem_next  = rem_step;
        dq_next   = q_step;
        iter_next = iter - ITER_W'(1);
        if (iter == '0) begin
          out_valid_next     = 1'b1;
          foreground_next    = fg_hold;
          frame_done_next    = 1'b1;
          empty_frame_next   = 1'b0;
          area_next          = area_sum;
          centroid_col_next  = q_clamp[CENT_W-1:0];
          area_sum_next      = '0;
          row_index_sum_next = '0;
          col_index_sum_next = '0;
          state_next         = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/btc_checker.sv
// port-level checks for the binary threshold centroid block, bound to the top
`default_nettype none

module btc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        end_of_frame,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        frame_done,
  input wire logic [18:0] area,
  input wire logic [8:0]  centroid_row,
  input wire logic [8:0]  centroid_col,
  input wire logic        empty_frame
);

  // a waiting result is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output not empty after reset");

  // an ordinary pixel gives a plain mask result in the next cycle
  a_pixel_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !end_of_frame |=> out_valid && !frame_done)
    else $error("pixel request gave no mask result");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_frame |-> frame_done && area == '0 &&
      centroid_row == '0 && centroid_col == '0)
    else $error("empty frame result carries statistics");

  a_plain_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_done |-> !empty_frame && area == '0)
    else $error("mask result carries frame fields");

endmodule

bind binary_threshold_centroid btc_checker u_btc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .end_of_frame (end_of_frame),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .frame_done   (frame_done),
  .area         (area),
  .centroid_row (centroid_row),
  .centroid_col (centroid_col),
  .empty_frame  (empty_frame)
);

`default_nettype wire

>>> tb/tb_binary_threshold_centroid.sv
// self-checking testbench for the binary threshold centroid block
`default_nettype none

module tb_binary_threshold_centroid;
  import btc_pkg::*;

  localparam int MAX_ROWS    = 512;
  localparam int MAX_COLUMNS = 512;

  typedef struct packed {
    logic [PIXEL_W-1:0] value;
    logic               last;
  } raster_px_t;

  typedef struct packed {
    logic              fg;
    logic              done;
    logic [AREA_W-1:0] area;
    logic [CENT_W-1:0] crow;
    logic [CENT_W-1:0] ccol;
    logic              empty;
  } pixel_stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [PIXEL_W-1:0] pixel = '0;
  logic               end_of_frame = 1'b0;

  logic              out_valid;
  logic              out_stall;
  logic              snk_stall = 1'b0;
  logic              long_hold = 1'b0;
  logic              foreground;
  logic              frame_done;
  logic [AREA_W-1:0] area;
  logic [CENT_W-1:0] centroid_row;
  logic [CENT_W-1:0] centroid_col;
  logic              empty_frame;

  assign out_stall = snk_stall | long_hold;

  binary_threshold_centroid #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel       (pixel),
    .end_of_frame(end_of_frame),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .foreground  (foreground),
    .frame_done  (frame_done),
    .area        (area),
    .centroid_row(centroid_row),
    .centroid_col(centroid_col),
    .empty_frame (empty_frame)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // register mirrors and raster position / accumulator copies
  logic [PIXEL_W-1:0] thr_cfg = THRESHOLD_RESET;
  logic [LW_W-1:0]    lw_cfg = LINE_WIDTH_RESET;
  int unsigned        col_pos = 0;
  int unsigned        row_pos = 0;
  logic [AREA_W-1:0]  fg_area = '0;
  logic [SUM_W-1:0]   row_sum = '0;
  logic [SUM_W-1:0]   col_sum = '0;

  raster_px_t   pending_pixels[$];
  pixel_stats_t stats_q[$];
  int           mismatch_cnt = 0;
  int           src_gap = 0;
  bit           src_burst = 1'b0;
  int           snk_wait = 0;
  bit           snk_burst = 1'b0;
  bit           pressure_go = 1'b0;

  function automatic logic [SUM_W-1:0] sum_sat(logic [SUM_W-1:0] acc, int unsigned pos);
    logic [SUM_W:0] wide;
    wide = {1'b0, acc} + (SUM_W + 1)'(pos);
    return (wide > {1'b0, SUM_MAX}) ? SUM_MAX : wide[SUM_W-1:0];
  endfunction

  function automatic pixel_stats_t predict_pixel_stats(logic [PIXEL_W-1:0] pix, logic eof);
    pixel_stats_t r;
    int unsigned  width;
    int unsigned  q;
    r = '0;
    r.fg = (pix < thr_cfg);
    width = (lw_cfg == 0) ? 1 : (lw_cfg > MAX_COLUMNS) ? MAX_COLUMNS : lw_cfg;
    if (r.fg) begin
      if (fg_area != AREA_MAX) fg_area = fg_area + 1'b1;
      row_sum = sum_sat(row_sum, row_pos);
      col_sum = sum_sat(col_sum, col_pos);
    end
    if (eof) begin
      r.done = 1'b1;
      if (fg_area == 0) begin
        r.empty = 1'b1;
      end else begin
        r.area = fg_area;
        q = row_sum / fg_area;
        r.crow = CENT_W'((q > MAX_ROWS - 1) ? MAX_ROWS - 1 : q);
        q = col_sum / fg_area;
        r.ccol = CENT_W'((q > MAX_COLUMNS - 1) ? MAX_COLUMNS - 1 : q);
      end
      fg_area = '0;
      row_sum = '0;
      col_sum = '0;
      col_pos = 0;
      row_pos = 0;
    end else begin
      col_pos++;
      if (col_pos >= width) begin
        col_pos = 0;
        if (row_pos < MAX_ROWS - 1) row_pos++;
      end
    end
    return r;
  endfunction

  task automatic cmp_field(string name, int unsigned expv, int unsigned actv);
    if (expv != actv) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, expv, actv);
      mismatch_cnt++;
    end
  endtask

  task automatic check_stats();
    pixel_stats_t e;
    if (stats_q.size() == 0) begin
      $display("%0t: result with none expected, expected nothing actual fg=%0d done=%0d",
               $time, foreground, frame_done);
      mismatch_cnt++;
    end else begin
      e = stats_q.pop_front();
      cmp_field("foreground", e.fg, foreground);
      cmp_field("frame_done", e.done, frame_done);
      cmp_field("area", e.area, area);
      cmp_field("centroid_row", e.crow, centroid_row);
      cmp_field("centroid_col", e.ccol, centroid_col);
      cmp_field("empty_frame", e.empty, empty_frame);
    end
  endtask

  // pixel driver
  always @(posedge clk) begin : driver
    raster_px_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      src_gap <= 0;
      col_pos = 0;
      row_pos = 0;
      fg_area = '0;
      row_sum = '0;
      col_sum = '0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) stats_q.push_back(predict_pixel_stats(pixel, end_of_frame));
      if (src_gap != 0) begin
        src_gap <= src_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_pixels.size() != 0) begin
        nxt = pending_pixels.pop_front();
        pixel <= nxt.value;
        end_of_frame <= nxt.last;
        in_valid <= 1'b1;
        if ($urandom_range(0, 47) == 0) src_burst = !src_burst;
        src_gap <= src_burst ? 0 : $urandom_range(0, 14);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : monitor
    int wait_n;
    if (rst) begin
      snk_stall <= 1'b0;
      snk_wait <= 0;
    end else begin
      wait_n = snk_wait;
      if (out_valid && !out_stall) begin
        check_stats();
        if ($urandom_range(0, 40) == 0) snk_burst = !snk_burst;
        wait_n = snk_burst ? 0 : $urandom_range(0, 14);
      end else if (wait_n != 0) begin
        wait_n--;
      end
      snk_wait <= wait_n;
      snk_stall <= (wait_n != 0);
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin : pressure
    wait (pressure_go);
    repeat (30) @(posedge clk);
    long_hold <= 1'b1;
    repeat (300) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin : watchdog
    #12_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic write_reg(logic reg_idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_idx == REG_THRESHOLD) thr_cfg = value[PIXEL_W-1:0];
    else lw_cfg = value[LW_W-1:0];
  endtask

  task automatic queue_pixel(logic [PIXEL_W-1:0] value, logic last);
    pending_pixels.push_back('{value: value, last: last});
  endtask

  function automatic logic [PIXEL_W-1:0] draw_pixel();
    case ($urandom_range(0, 5))
      0: return (thr_cfg == 0) ? '0 : thr_cfg - 1'b1;
      1: return thr_cfg;
      2: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      default: return PIXEL_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic queue_frame(int len);
    for (int i = 0; i < len; i++) queue_pixel(draw_pixel(), i == len - 1);
  endtask

  // every request in gives one request out, so idle means nothing left either way
  task automatic wait_idle();
    while (pending_pixels.size() != 0 || in_valid || stats_q.size() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int queued;
    int len;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings: empty frame, single pixel at origin, threshold edge
    queue_pixel(8'd255, 1'b1);
    queue_pixel(8'd0, 1'b1);
    queue_pixel(8'd138, 1'b0);
    queue_pixel(8'd139, 1'b0);
    queue_pixel(8'd0, 1'b0);
    queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd140, 1'b1);
    wait_idle();

    // nothing can be foreground
    write_reg(REG_THRESHOLD, 32'd0);
    queue_pixel(8'd0, 1'b0);
    queue_pixel(8'd255, 1'b1);
    wait_idle();

    // one pixel per row
    write_reg(REG_THRESHOLD, 32'd255);
    write_reg(REG_LINE_WIDTH, 32'd1);
    queue_pixel(8'd254, 1'b0);
    queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd0, 1'b0);
    queue_pixel(8'd7, 1'b0);
    queue_pixel(8'd128, 1'b1);
    wait_idle();

    // zero width clamps up to one
    write_reg(REG_LINE_WIDTH, 32'd0);
    queue_pixel(8'd1, 1'b0);
    queue_pixel(8'd200, 1'b0);
    queue_pixel(8'd2, 1'b1);
    wait_idle();

    write_reg(REG_THRESHOLD, 32'd128);
    write_reg(REG_LINE_WIDTH, 32'd2);
    queue_pixel(8'd127, 1'b0);
    queue_pixel(8'd128, 1'b0);
    queue_pixel(8'd0, 1'b0);
    queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd127, 1'b1);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 5))
        0: write_reg(REG_THRESHOLD, 32'd0);
        1: write_reg(REG_THRESHOLD, 32'd255);
        default: write_reg(REG_THRESHOLD, $urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 8))
        0: write_reg(REG_LINE_WIDTH, 32'd1);
        1: write_reg(REG_LINE_WIDTH, 32'd512);
        2: write_reg(REG_LINE_WIDTH, 32'd0);
        3: write_reg(REG_LINE_WIDTH, 32'd1023);
        8: write_reg(REG_LINE_WIDTH, $urandom_range(1, 1023));
        default: write_reg(REG_LINE_WIDTH, $urandom_range(1, 16));
      endcase
      queued = 0;
      while (queued < 45) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
        queue_frame(len);
        queued += len;
      end
      if (ph == 0) pressure_go = 1'b1;
      wait_idle();
    end

    repeat (60) @(posedge clk);
    if (mismatch_cnt == 0 && stats_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
